[src/cpu_pkg.sv]
// Package for the camera pose update block: payload structs, constants,
// CORDIC arctangent table, controller/datapath command types. No dependencies.
`default_nettype none
package cpu_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

    localparam logic signed [31:0] LOOK_Y_RST = 32'sd65536;
    localparam logic signed [31:0] LOOK_Z_RST = 32'sd32768;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_MOVE   = 2'd1,
        ACT_ROTATE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] speed;
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_pos_z;
        logic signed [31:0] load_view_x;
        logic signed [31:0] load_view_y;
        logic signed [31:0] load_view_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [31:0] view_z;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MAT,
        ST_APPLY,
        ST_OUT
    } state_t;

    // datapath micro-ops
    typedef enum logic [2:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_CORDIC,
        OP_MAT,
        OP_APPLY,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] step;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
    } status_t;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        logic signed [31:0] r;
        begin
            unique case (i)
                5'd0:    r = 32'h3243F6A8;
                5'd1:    r = 32'h1DAC6705;
                5'd2:    r = 32'h0FADBAFC;
                5'd3:    r = 32'h07F56EA6;
                5'd4:    r = 32'h03FEAB76;
                5'd5:    r = 32'h01FFD55B;
                5'd6:    r = 32'h00FFFAAA;
                5'd7:    r = 32'h007FFF55;
                5'd8:    r = 32'h003FFFEA;
                5'd9:    r = 32'h001FFFFD;
                5'd10:   r = 32'h000FFFFF;
                5'd11:   r = 32'h0007FFFF;
                5'd12:   r = 32'h0003FFFF;
                5'd13:   r = 32'h0001FFFF;
                5'd14:   r = 32'h0000FFFF;
                5'd15:   r = 32'h00007FFF;
                5'd16:   r = 32'h00003FFF;
                5'd17:   r = 32'h00001FFF;
                5'd18:   r = 32'h00000FFF;
                5'd19:   r = 32'h000007FF;
                5'd20:   r = 32'h000003FF;
                5'd21:   r = 32'h000001FF;
                5'd22:   r = 32'h000000FF;
                5'd23:   r = 32'h0000007F;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sh07FFFFFFF)
                return 32'sh7FFFFFFF;
            else if (v < -64'sh080000000)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

[src/camera_pose_update.sv]
// Top level of the camera pose update block: controller plus datapath.
// Depends on cpu_pkg, cpu_ctrl, cpu_dp.
`default_nettype none
// Handles one transaction at a time. For load, move and unused action codes
// the controller goes from capture through a finish step to the output state;
// for rotate it runs the sequential CORDIC iterations, then uses the single
// shared multiplier to build and apply the rotation matrix, before the output
// state. The result stays on out_data until taken; in_ready is high only
// while idle.
module camera_pose_update #(
    parameter int CORDIC_STEPS = cpu_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cpu_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cpu_pkg::out_item_t      out_data
);
    import cpu_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic    busy;
    logic    pend;
    logic    in_fire, out_fire;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = !busy;
    assign out_valid = pend;

    cpu_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .cmd(cmd), .busy(busy), .out_pending(pend)
    );

    cpu_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_data),
        .sts(sts), .pose(out_data)
    );

    a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("ready right after accept");
endmodule
`default_nettype wire

[src/cpu_ctrl.sv]
// Controller FSM for the camera pose update block.
// Depends on cpu_pkg.
`default_nettype none
module cpu_ctrl #(
    parameter int CORDIC_STEPS = cpu_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic             out_fire,
    input  wire cpu_pkg::status_t sts,
    output cpu_pkg::cmd_t         cmd,
    output logic                  busy,
    output logic                  out_pending
);
    import cpu_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd.op      = OP_NOP;
        cmd.step    = step_reg;
        busy        = 1'b1;
        out_pending = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.op    = OP_CAPTURE;
                    step_next = '0;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (sts.action != ACT_ROTATE)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op = OP_CORDIC;
                    if (step_reg == LAST_STEP)
                    begin
                        step_next  = '0;
                        state_next = ST_MAT;
                    end
                    else
                        step_next = step_reg + 5'd1;
                end
            end
            ST_MAT:
            begin
                // steps 0..2: s*a; 3..5: t*a; 6..14: products, entries latched on 14
                cmd.op = OP_MAT;
                if (step_reg == 5'd14)
                begin
                    step_next  = '0;
                    state_next = ST_APPLY;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_APPLY:
            begin
                // 9 products, then 3 writebacks
                cmd.op = OP_APPLY;
                if (step_reg == 5'd11)
                    state_next = ST_OUT;
                step_next = step_reg + 5'd1;
            end
            ST_OUT:
            begin
                out_pending = 1'b1;
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[src/cpu_dp.sv]
// Datapath for the camera pose update block: pose registers, CORDIC,
// one shared multiplier for matrix build and apply. Depends on cpu_pkg.
`default_nettype none
module cpu_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cpu_pkg::cmd_t     cmd,
    input  wire cpu_pkg::in_item_t in_item,
    output cpu_pkg::status_t       sts,
    output cpu_pkg::out_item_t     pose
);
    import cpu_pkg::*;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] look_reg [3];
    in_item_t           item_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic signed [35:0] sv_reg [3];
    logic signed [35:0] ta_reg [3];
    logic signed [35:0] tv_reg [3][3];
    logic signed [35:0] m_reg  [3][3];
    logic signed [63:0] acc_reg [3];

    logic signed [33:0] theta;
    logic signed [33:0] zfold;
    logic               fold;
    logic signed [35:0] c_fin, s_fin, t_fin;
    logic signed [15:0] ax [3];
    logic signed [33:0] dv [3];
    logic [3:0]         mi;
    logic [1:0]         ri, ci;
    logic signed [35:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] prod;
    logic signed [35:0] prod_r14;
    logic signed [33:0] dx, dy, zst;
    logic signed [65:0] mv_px, mv_pz;
    logic signed [63:0] dlx, dlz;
    logic signed [63:0] accr;

    assign sts.action = item_reg.action;
    assign ax[0] = item_reg.axis_x;
    assign ax[1] = item_reg.axis_y;
    assign ax[2] = item_reg.axis_z;

    always_comb
    begin
        theta = 34'(item_reg.angle) <<< 17;
        fold  = 1'b0;
        zfold = theta;
        if (theta > HALF_PI_Q30)
        begin
            fold  = 1'b1;
            zfold = theta - PI_Q30;
        end
        else if (theta < -HALF_PI_Q30)
        begin
            fold  = 1'b1;
            zfold = theta + PI_Q30;
        end
        c_fin = flip_reg ? -36'(cx_reg) : 36'(cx_reg);
        s_fin = flip_reg ? -36'(cy_reg) : 36'(cy_reg);
        t_fin = 36'(ONE_Q30) - c_fin;
        for (int k = 0; k < 3; k++)
            dv[k] = 34'(look_reg[k]) - 34'(pos_reg[k]);
        dx  = cy_reg >>> cmd.step;
        dy  = cx_reg >>> cmd.step;
        zst = 34'(atan_q30(cmd.step));
    end

    // row/column of the current matrix element
    always_comb
    begin
        if (cmd.op == OP_MAT)
            mi = 4'(cmd.step - 5'd6);
        else if (cmd.op == OP_APPLY && cmd.step < 5'd9)
            mi = 4'(cmd.step);
        else
            mi = '0;
        unique case (mi)
            4'd0:    begin ri = 2'd0; ci = 2'd0; end
            4'd1:    begin ri = 2'd0; ci = 2'd1; end
            4'd2:    begin ri = 2'd0; ci = 2'd2; end
            4'd3:    begin ri = 2'd1; ci = 2'd0; end
            4'd4:    begin ri = 2'd1; ci = 2'd1; end
            4'd5:    begin ri = 2'd1; ci = 2'd2; end
            4'd6:    begin ri = 2'd2; ci = 2'd0; end
            4'd7:    begin ri = 2'd2; ci = 2'd1; end
            4'd8:    begin ri = 2'd2; ci = 2'd2; end
            default: begin ri = 2'd0; ci = 2'd0; end
        endcase
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == OP_MAT)
        begin
            if (cmd.step < 5'd3)
            begin
                mul_a = s_fin;
                mul_b = 32'(ax[cmd.step[1:0]]);
            end
            else if (cmd.step < 5'd6)
            begin
                mul_a = t_fin;
                mul_b = 32'(ax[2'(cmd.step - 5'd3)]);
            end
            else
            begin
                mul_a = ta_reg[ri];
                mul_b = 32'(ax[ci]);
            end
        end
        else if (cmd.op == OP_APPLY)
        begin
            mul_a = 36'(dv[ci]);
            mul_b = 32'((m_reg[ri][ci] + 36'sd32) >>> 6);
        end
    end

    assign prod     = 66'(mul_a) * 66'(mul_b);
    assign prod_r14 = 36'((prod + 66'sd8192) >>> 14);

    assign mv_px = 66'(dv[0]) * 66'(item_reg.speed);
    assign mv_pz = 66'(dv[2]) * 66'(item_reg.speed);
    assign dlx   = 64'((mv_px + 66'sd32768) >>> 16);
    assign dlz   = 64'((mv_pz + 66'sd32768) >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0]  <= '0;
            pos_reg[1]  <= '0;
            pos_reg[2]  <= '0;
            look_reg[0] <= '0;
            look_reg[1] <= LOOK_Y_RST;
            look_reg[2] <= LOOK_Z_RST;
        end
        else
        begin
            unique case (cmd.op)
                OP_FINISH:
                begin
                    if (item_reg.action == ACT_LOAD)
                    begin
                        pos_reg[0]  <= item_reg.load_pos_x;
                        pos_reg[1]  <= item_reg.load_pos_y;
                        pos_reg[2]  <= item_reg.load_pos_z;
                        look_reg[0] <= item_reg.load_view_x;
                        look_reg[1] <= item_reg.load_view_y;
                        look_reg[2] <= item_reg.load_view_z;
                    end
                    else if (item_reg.action == ACT_MOVE)
                    begin
                        pos_reg[0]  <= sat32(64'(pos_reg[0]) + dlx);
                        pos_reg[2]  <= sat32(64'(pos_reg[2]) + dlz);
                        look_reg[0] <= sat32(64'(look_reg[0]) + dlx);
                        look_reg[2] <= sat32(64'(look_reg[2]) + dlz);
                    end
                end
                OP_APPLY:
                begin
                    if (cmd.step >= 5'd9)
                        look_reg[2'(cmd.step - 5'd9)] <= sat32(64'(pos_reg[2'(cmd.step - 5'd9)])
                            + accr);
                end
                default: ;
            endcase
        end
    end

    assign accr = (acc_reg[2'(cmd.step - 5'd9)] + 64'sh800000) >>> 24;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                item_reg <= in_item;
            end
            OP_CORDIC:
            begin
                if (cmd.step == 5'd0)
                begin
                    flip_reg <= fold;
                    cx_reg   <= CORDIC_K;
                    if (zfold >= 0)
                    begin
                        cy_reg <= CORDIC_K;
                        cz_reg <= zfold - zst;
                    end
                    else
                    begin
                        cy_reg <= -CORDIC_K;
                        cz_reg <= zfold + zst;
                    end
                end
                else if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - zst;
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + zst;
                end
            end
            OP_MAT:
            begin
                if (cmd.step < 5'd3)
                    sv_reg[cmd.step[1:0]] <= prod_r14;
                else if (cmd.step < 5'd6)
                    ta_reg[2'(cmd.step - 5'd3)] <= prod_r14;
                else
                    tv_reg[ri][ci] <= prod_r14;
                if (cmd.step == 5'd14)
                begin
                    m_reg[0][0] <= c_fin + tv_reg[0][0];
                    m_reg[0][1] <= tv_reg[0][1] - sv_reg[2];
                    m_reg[0][2] <= tv_reg[0][2] + sv_reg[1];
                    m_reg[1][0] <= tv_reg[0][1] + sv_reg[2];
                    m_reg[1][1] <= c_fin + tv_reg[1][1];
                    m_reg[1][2] <= tv_reg[1][2] - sv_reg[0];
                    m_reg[2][0] <= tv_reg[0][2] - sv_reg[1];
                    m_reg[2][1] <= tv_reg[1][2] + sv_reg[0];
                    m_reg[2][2] <= c_fin + prod_r14;
                end
            end
            OP_APPLY:
            begin
                if (cmd.step < 5'd9)
                begin
                    if (ci == 2'd0)
                        acc_reg[ri] <= 64'(prod);
                    else
                        acc_reg[ri] <= acc_reg[ri] + 64'(prod);
                end
            end
            default: ;
        endcase
    end

    assign pose.pos_x  = pos_reg[0];
    assign pose.pos_y  = pos_reg[1];
    assign pose.pos_z  = pos_reg[2];
    assign pose.view_x = look_reg[0];
    assign pose.view_y = look_reg[1];
    assign pose.view_z = look_reg[2];
endmodule
`default_nettype wire

[sim/camera_pose_update_tb.sv]
// Testbench for camera_pose_update: directed table plus random transactions,
// checked against an in-bench pose predictor. Depends on cpu_pkg and the RTL.
`default_nettype none
module camera_pose_update_tb;
    import cpu_pkg::*;

    localparam int STEPS = 16;
    localparam int N_RANDOM = 700;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int errors = 0;

    longint pose_pos[3];
    longint pose_look[3];
    out_item_t pending_poses[$];

    typedef struct {
        in_item_t item;
        bit has_fixed;
        out_item_t fixed;
    } row_t;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    camera_pose_update #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void cordic_sin_cos(longint ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = ang * 131072;
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic out_item_t next_pose(in_item_t it);
        longint s, c, t, dl[3], ax[3], sv[3], tv[3][3], m[3][3], acc, sp, dxm, dzm;
        out_item_t r;
        case (action_t'(it.action))
            ACT_LOAD:
            begin
                pose_pos[0] = it.load_pos_x; pose_pos[1] = it.load_pos_y;
                pose_pos[2] = it.load_pos_z;
                pose_look[0] = it.load_view_x; pose_look[1] = it.load_view_y;
                pose_look[2] = it.load_view_z;
            end
            ACT_MOVE:
            begin
                sp = it.speed;
                dxm = round_shift((pose_look[0] - pose_pos[0]) * sp, 16);
                dzm = round_shift((pose_look[2] - pose_pos[2]) * sp, 16);
                pose_pos[0] = clamp32(pose_pos[0] + dxm);
                pose_pos[2] = clamp32(pose_pos[2] + dzm);
                pose_look[0] = clamp32(pose_look[0] + dxm);
                pose_look[2] = clamp32(pose_look[2] + dzm);
            end
            ACT_ROTATE:
            begin
                ax[0] = it.axis_x; ax[1] = it.axis_y; ax[2] = it.axis_z;
                cordic_sin_cos(longint'(it.angle), s, c);
                t = 64'sd1073741824 - c;
                for (int i = 0; i < 3; i++)
                begin
                    dl[i] = pose_look[i] - pose_pos[i];
                    sv[i] = round_shift(s * ax[i], 14);
                    for (int j = 0; j < 3; j++)
                        tv[i][j] = round_shift(round_shift(t * ax[i], 14) * ax[j], 14);
                end
                m[0][0] = c + tv[0][0]; m[0][1] = tv[0][1] - sv[2];
                m[0][2] = tv[0][2] + sv[1]; m[1][0] = tv[0][1] + sv[2];
                m[1][1] = c + tv[1][1]; m[1][2] = tv[1][2] - sv[0];
                m[2][0] = tv[0][2] - sv[1]; m[2][1] = tv[1][2] + sv[0];
                m[2][2] = c + tv[2][2];
                for (int i = 0; i < 3; i++)
                begin
                    acc = 0;
                    for (int j = 0; j < 3; j++)
                        acc += round_shift(m[i][j], 6) * dl[j];
                    pose_look[i] = clamp32(pose_pos[i] + round_shift(acc, 24));
                end
            end
            default: ;
        endcase
        r.pos_x = pose_pos[0][31:0]; r.pos_y = pose_pos[1][31:0];
        r.pos_z = pose_pos[2][31:0];
        r.view_x = pose_look[0][31:0]; r.view_y = pose_look[1][31:0];
        r.view_z = pose_look[2][31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 4))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it = in_item_t'(290'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom}));
        case ($urandom_range(0, 19))
            0, 1, 2, 3: it.action = ACT_LOAD;
            19: it.action = ACT_NONE;
            4, 5, 6, 7, 8, 9: it.action = ACT_MOVE;
            default: it.action = ACT_ROTATE;
        endcase
        if ($urandom_range(0, 3) != 0)
        begin
            // keep points modest so later moves do more than saturate
            it.load_pos_x = 32'($signed($urandom) >>> $urandom_range(6, 14));
            it.load_pos_y = 32'($signed($urandom) >>> $urandom_range(6, 14));
            it.load_pos_z = 32'($signed($urandom) >>> $urandom_range(6, 14));
            it.load_view_x = 32'($signed($urandom) >>> $urandom_range(6, 14));
            it.load_view_y = 32'($signed($urandom) >>> $urandom_range(6, 14));
            it.load_view_z = 32'($signed($urandom) >>> $urandom_range(6, 14));
            it.speed = 32'($signed($urandom) >>> $urandom_range(12, 20));
        end
        if ($urandom_range(0, 9) != 0)
            it.angle = 16'($signed($urandom_range(0, 51472)) - 25736);
        if ($urandom_range(0, 9) != 0)
        begin
            it.axis_x = rand_axis(); it.axis_y = rand_axis(); it.axis_z = rand_axis();
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        pending_poses.push_back(next_pose(it));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                errors++;
            end
            else if (pending_poses[0] !== out_data)
            begin
                $display("%0t: pose mismatch expected %h actual %h", $time,
                         pending_poses[0], out_data);
                errors++;
                void'(pending_poses.pop_front());
            end
            else
                void'(pending_poses.pop_front());
        end
    end

    row_t rows[$];

    task automatic build_rows();
        row_t r;
        in_item_t it;
        it = '0;
        it.action = ACT_NONE;
        r.item = it; r.has_fixed = 1;
        r.fixed = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, LOOK_Y_RST, LOOK_Z_RST};
        rows.push_back(r);
        it = '0; it.action = ACT_LOAD;
        it.load_pos_x = 32'sh7FFFFFFF; it.load_pos_y = 32'sh80000000;
        it.load_pos_z = 32'sh7FFFFFFF; it.load_view_x = 32'sh80000000;
        it.load_view_y = 32'sh7FFFFFFF; it.load_view_z = 32'sh80000000;
        r.item = it; r.has_fixed = 1;
        r.fixed = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                    32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
        rows.push_back(r);
        // x and z of both points saturate low
        it.action = ACT_MOVE; it.speed = 32'sh7FFFFFFF;
        r.item = it; r.has_fixed = 1;
        r.fixed = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
        rows.push_back(r);
        it.speed = 32'sh80000000;
        r.item = it; r.has_fixed = 0; rows.push_back(r);
        it.action = ACT_NONE; r.item = it; rows.push_back(r);
        it = '0; it.action = ACT_LOAD;
        it.load_pos_x = 32'sd65536; it.load_view_x = 32'sd196608;
        it.load_view_y = 32'sd131072; it.load_view_z = -32'sd65536;
        r.item = it; rows.push_back(r);
        foreach (rows[k]) ;
        for (int k = 0; k < 14; k++)
        begin
            it.action = (k % 3 == 2) ? ACT_MOVE : ACT_ROTATE;
            it.speed = (k == 2) ? -32'sd32768 : 32'sd16384;
            case (k % 7)
                0: it.angle = 16'sd25736;
                1: it.angle = -16'sd25736;
                2: it.angle = 16'sh7FFF;
                3: it.angle = 16'sh8000;
                4: it.angle = 16'sd12868;
                5: it.angle = 16'sd0;
                default: it.angle = -16'sd12869;
            endcase
            it.axis_x = (k % 4 == 0) ? 16'sd16384 : 16'sd0;
            it.axis_y = (k % 4 == 1) ? -16'sd16384 : 16'sd0;
            it.axis_z = (k % 4 == 2) ? 16'sd16384 : 16'sd0;
            if (k % 4 == 3)
            begin
                it.axis_x = 16'sh7FFF; it.axis_y = 16'sh8000; it.axis_z = 16'sh7FFF;
            end
            r.item = it; rows.push_back(r);
        end
    endtask

    initial
    begin
        #4000000;
        $display("camera_pose_update_tb: FAIL");
        $finish;
    end

    initial
    begin
        out_item_t got;
        pose_pos = '{0, 0, 0};
        pose_look = '{0, 65536, 32768};
        build_rows();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[k])
        begin
            got = next_pose(rows[k].item);
            if (rows[k].has_fixed && got !== rows[k].fixed)
            begin
                $display("%0t: table row %0d expected %h actual %h", $time, k,
                         rows[k].fixed, got);
                errors++;
            end
        end
        pose_pos = '{0, 0, 0};
        pose_look = '{0, 65536, 32768};
        foreach (rows[k])
            send_item(rows[k].item);
        drain();
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 75 : (phase == 3) ? 37 : 0;
            recv_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 37 : 0;
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                if (phase == 0 && n == 20)
                    hold_off_cycles <= 400;
                send_item(rand_item());
            end
            drain();
        end
        if (errors == 0)
            $display("camera_pose_update_tb: PASS");
        else
            $display("camera_pose_update_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
